@@ hdl/adu_pkg.sv @@
// Shared constants, types and arithmetic helpers for the AdaDelta update unit.
`default_nettype none
package adu_pkg;

    localparam int ELEMENT_COUNT = 4096;
    localparam int IDX_W         = 12;
    localparam int VAL_W         = 32;
    localparam int AVG_W         = 48;
    localparam int NUM_W         = AVG_W + 1;
    localparam int PROD_W        = 111;
    localparam int QUO_W         = 63;
    localparam int ROOT_W        = 32;
    localparam int REM_W         = ROOT_W + 2;
    localparam int SQRT_X_W      = 2 * ROOT_W;
    localparam int RHO_W         = 16;
    localparam int EPS_W         = 32;
    localparam int SCALE_W       = 31;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 32;

    localparam int FRONT_STAGES  = 10;
    localparam int DIV_STAGES    = QUO_W + 1;
    localparam int SQRT_STAGES   = ROOT_W;
    localparam int BACK_STAGES   = 5;
    localparam int PIPE_DEPTH    = FRONT_STAGES + DIV_STAGES + SQRT_STAGES + BACK_STAGES;

    localparam logic [RHO_W-1:0]   DECAY_RATE_RESET     = 16'd62259;
    localparam logic [EPS_W-1:0]   STABILITY_TERM_RESET = 32'd4295;
    localparam logic [SCALE_W-1:0] STEP_SCALE_RESET     = 31'd16777216;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DECAY_RATE     = 2'd0,
        REG_STABILITY_TERM = 2'd1,
        REG_STEP_SCALE     = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [RHO_W-1:0]   decay_rate;
        logic [EPS_W-1:0]   stability_term;
        logic [SCALE_W-1:0] step_scale;
    } cfg_t;

    // per-word fields that ride along the pipeline
    typedef struct packed {
        logic [IDX_W-1:0]        idx;
        logic                    inrange;
        logic signed [VAL_W-1:0] w;
        logic                    gneg;
        logic                    gzero;
        logic [AVG_W-1:0]        edx_old;
        logic [AVG_W-1:0]        eg_new;
        logic                    sat;
    } side_t;

    // (x + 2^15) >> 16, Q8.24 square into Q16.32
    function automatic logic [AVG_W-1:0] sq_round(input logic [63:0] x);
        logic [64:0] s;
        s = 65'(x) + 65'(32768);
        return s[63:16];
    endfunction

    // final add of the running average blend; returns {clipped, value}
    function automatic logic [AVG_W:0] avg_finish(input logic [63:0] p_old,
                                                  input logic [63:0] p_new);
        logic [64:0]    s;
        logic [AVG_W:0] v;
        s = 65'(p_old) + 65'(p_new) + 65'(32768);
        v = s[64:16];
        if (v[AVG_W])
        begin
            return {1'b1, {AVG_W{1'b1}}};
        end
        return {1'b0, v[AVG_W-1:0]};
    endfunction

endpackage
`default_nettype wire

@@ hdl/adu_if.sv @@
// Item and result channel interfaces.
`default_nettype none
interface adu_item_if
    import adu_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        element_index;
    logic signed [VAL_W-1:0] weight_value;
    logic signed [VAL_W-1:0] gradient_value;

    modport source (output valid, element_index, weight_value, gradient_value, input ready);
    modport sink (input valid, element_index, weight_value, gradient_value, output ready);
endinterface

interface adu_result_if
    import adu_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] new_weight;
    logic signed [VAL_W-1:0] applied_step;
    logic                    saturated;

    modport source (output valid, new_weight, applied_step, saturated, input ready);
    modport sink (input valid, new_weight, applied_step, saturated, output ready);
endinterface
`default_nettype wire

@@ hdl/adu_avg_mem.sv @@
// Running average store, one write port and one registered read port.
`default_nettype none
module adu_avg_mem
    import adu_pkg::*;
(
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  logic [AVG_W-1:0] wdata,
    input  logic             re,
    input  logic [IDX_W-1:0] raddr,
    output logic [AVG_W-1:0] rdata
);

    logic [AVG_W-1:0] mem [ELEMENT_COUNT];
    logic [AVG_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

@@ hdl/adu_front.sv @@
// Front stages: gradient average update and the wide numerator product.
`default_nettype none
module adu_front
    import adu_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  logic                    accept,
    input  logic [IDX_W-1:0]        element_index,
    input  logic signed [VAL_W-1:0] weight_value,
    input  logic signed [VAL_W-1:0] gradient_value,
    input  logic [AVG_W-1:0]        eg_rdata,
    input  logic [AVG_W-1:0]        edx_rdata,
    input  cfg_t                    cfg,
    output logic                    valid,
    output side_t                   side,
    output logic [PROD_W-1:0]       prod,
    output logic [NUM_W-1:0]        den
);

    logic  vld_reg  [FRONT_STAGES];
    side_t side_reg [FRONT_STAGES];
    side_t side_next[FRONT_STAGES];

    logic [VAL_W-1:0] ug_reg [7];
    logic [VAL_W-1:0] ug_next[7];

    logic [63:0]      ugsq_reg, ugsq_next;
    logic [63:0]      pg_old_reg [3];
    logic [63:0]      pg_old_next[3];
    logic [AVG_W-1:0] sq_reg, sq_next;
    logic [63:0]      pg_new_reg, pg_new_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [NUM_W-1:0] den_reg [5];
    logic [NUM_W-1:0] den_next[5];
    logic [56:0]      alo_reg, alo_next;
    logic [55:0]      ahi_reg, ahi_next;
    logic [80:0]      a_reg, a_next;
    logic [58:0]      b0_reg, b0_next, b1_reg, b1_next;
    logic [58:0]      b2_reg [2];
    logic [58:0]      b2_next[2];
    logic [85:0]      s_reg, s_next;
    logic [PROD_W-1:0] p_reg, p_next;

    logic [16:0]      one_minus_rho;
    logic [AVG_W:0]   eg_fin;
    logic [AVG_W-1:0] eg_old;

    always_comb
    begin
        one_minus_rho = 17'h10000 - {1'b0, cfg.decay_rate};
        eg_old        = side_reg[0].inrange ? eg_rdata : '0;

        for (int k = 0; k < FRONT_STAGES; k++)
        begin
            side_next[k] = side_reg[(k == 0) ? 0 : k - 1];
        end
        for (int k = 1; k < 7; k++)
        begin
            ug_next[k] = ug_reg[k - 1];
        end

        // stage 0: unpack the word
        side_next[0].idx     = element_index;
        side_next[0].inrange = (32'(element_index) < ELEMENT_COUNT);
        side_next[0].w       = weight_value;
        side_next[0].gneg    = gradient_value[VAL_W-1];
        side_next[0].gzero   = (gradient_value == '0);
        side_next[0].edx_old = '0;
        side_next[0].eg_new  = '0;
        side_next[0].sat     = 1'b0;
        ug_next[0] = gradient_value[VAL_W-1] ? (VAL_W'(0) - VAL_W'(gradient_value))
                                             : VAL_W'(gradient_value);

        // stage 1: g^2 and rho * old average
        side_next[1].edx_old = side_reg[0].inrange ? edx_rdata : '0;
        ugsq_next      = 64'(ug_reg[0]) * 64'(ug_reg[0]);
        pg_old_next[0] = 64'(cfg.decay_rate) * 64'(eg_old);

        // stage 2
        sq_next        = sq_round(ugsq_reg);
        pg_old_next[1] = pg_old_reg[0];

        // stage 3
        pg_new_next    = 64'(one_minus_rho) * 64'(sq_reg);
        pg_old_next[2] = pg_old_reg[1];

        // stage 4: new gradient average
        eg_fin = avg_finish(pg_old_reg[2], pg_new_reg);
        side_next[4].eg_new = eg_fin[AVG_W-1:0];
        side_next[4].sat    = side_reg[3].sat | eg_fin[AVG_W];
        num_next = NUM_W'(side_reg[3].edx_old) + NUM_W'(cfg.stability_term);

        // stage 5: denominator, ug * num in two halves
        den_next[0] = NUM_W'(side_reg[4].eg_new) + NUM_W'(cfg.stability_term);
        if (den_next[0] == '0)
        begin
            den_next[0] = NUM_W'(1);
        end
        alo_next = 57'(ug_reg[4]) * 57'(num_reg[24:0]);
        ahi_next = 56'(ug_reg[4]) * 56'(num_reg[NUM_W-1:25]);
        for (int k = 1; k < 5; k++)
        begin
            den_next[k] = den_reg[k - 1];
        end

        // stage 6
        a_next = 81'(alo_reg) + (81'(ahi_reg) << 25);

        // stage 7: ug * A in three slices
        b0_next    = 59'(ug_reg[6]) * 59'(a_reg[26:0]);
        b1_next    = 59'(ug_reg[6]) * 59'(a_reg[53:27]);
        b2_next[0] = 59'(ug_reg[6]) * 59'(a_reg[80:54]);

        // stages 8 and 9: fold the slices
        s_next     = 86'(b0_reg) + (86'(b1_reg) << 27);
        b2_next[1] = b2_reg[0];
        p_next     = PROD_W'(113'(s_reg) + (113'(b2_reg[1]) << 54));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < FRONT_STAGES; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= accept;
            for (int k = 1; k < FRONT_STAGES; k++)
            begin
                vld_reg[k] <= vld_reg[k - 1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg   <= side_next;
            ug_reg     <= ug_next;
            ugsq_reg   <= ugsq_next;
            pg_old_reg <= pg_old_next;
            sq_reg     <= sq_next;
            pg_new_reg <= pg_new_next;
            num_reg    <= num_next;
            den_reg    <= den_next;
            alo_reg    <= alo_next;
            ahi_reg    <= ahi_next;
            a_reg      <= a_next;
            b0_reg     <= b0_next;
            b1_reg     <= b1_next;
            b2_reg     <= b2_next;
            s_reg      <= s_next;
            p_reg      <= p_next;
        end
    end

    assign valid = vld_reg[FRONT_STAGES-1];
    assign side  = side_reg[FRONT_STAGES-1];
    assign prod  = p_reg;
    assign den   = den_reg[4];

endmodule
`default_nettype wire

@@ hdl/adu_div.sv @@
// Restoring divider, one quotient bit per stage; clamps when the quotient needs 64 bits.
`default_nettype none
module adu_div
    import adu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              valid_in,
    input  side_t             side_in,
    input  logic [PROD_W-1:0] prod,
    input  logic [NUM_W-1:0]  den,
    output logic              valid,
    output side_t             side,
    output logic [QUO_W-1:0]  quo
);

    logic             vld_reg  [DIV_STAGES];
    side_t            side_reg [DIV_STAGES];
    logic [NUM_W-1:0] den_reg  [DIV_STAGES];
    logic             over_reg [DIV_STAGES];
    logic [NUM_W-1:0] rem_reg  [DIV_STAGES];
    logic [QUO_W-1:0] low_reg  [DIV_STAGES];
    logic [QUO_W-1:0] q_reg    [DIV_STAGES];

    side_t            side_next[DIV_STAGES];
    logic [NUM_W-1:0] den_next [DIV_STAGES];
    logic             over_next[DIV_STAGES];
    logic [NUM_W-1:0] rem_next [DIV_STAGES];
    logic [QUO_W-1:0] low_next [DIV_STAGES];
    logic [QUO_W-1:0] q_next   [DIV_STAGES];

    logic [NUM_W:0] trial;
    logic           take;

    always_comb
    begin
        trial = '0;
        take  = 1'b0;

        // stage 0: the top bits form the first partial remainder
        side_next[0] = side_in;
        den_next[0]  = den;
        over_next[0] = NUM_W'(prod[PROD_W-1:QUO_W]) >= den;
        rem_next[0]  = NUM_W'(prod[PROD_W-1:QUO_W]);
        low_next[0]  = prod[QUO_W-1:0];
        q_next[0]    = '0;

        for (int k = 1; k < DIV_STAGES; k++)
        begin
            trial = {rem_reg[k - 1], low_reg[k - 1][QUO_W-1]};
            take  = trial >= {1'b0, den_reg[k - 1]};
            rem_next[k]  = take ? NUM_W'(trial - {1'b0, den_reg[k - 1]}) : NUM_W'(trial);
            low_next[k]  = low_reg[k - 1] << 1;
            q_next[k]    = {q_reg[k - 1][QUO_W-2:0], take};
            side_next[k] = side_reg[k - 1];
            den_next[k]  = den_reg[k - 1];
            over_next[k] = over_reg[k - 1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= valid_in;
            for (int k = 1; k < DIV_STAGES; k++)
            begin
                vld_reg[k] <= vld_reg[k - 1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg <= side_next;
            den_reg  <= den_next;
            over_reg <= over_next;
            rem_reg  <= rem_next;
            low_reg  <= low_next;
            q_reg    <= q_next;
        end
    end

    assign valid = vld_reg[DIV_STAGES-1];
    assign side  = side_reg[DIV_STAGES-1];
    assign quo   = over_reg[DIV_STAGES-1] ? {QUO_W{1'b1}} : q_reg[DIV_STAGES-1];

endmodule
`default_nettype wire

@@ hdl/adu_sqrt.sv @@
// Digit-by-digit integer square root, one root bit per stage.
`default_nettype none
module adu_sqrt
    import adu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              valid_in,
    input  side_t             side_in,
    input  logic [QUO_W-1:0]  radicand,
    output logic              valid,
    output side_t             side,
    output logic [ROOT_W-1:0] root
);

    logic                vld_reg  [SQRT_STAGES];
    side_t               side_reg [SQRT_STAGES];
    logic [SQRT_X_W-1:0] x_reg    [SQRT_STAGES];
    logic [REM_W-1:0]    rem_reg  [SQRT_STAGES];
    logic [ROOT_W-1:0]   root_reg [SQRT_STAGES];

    side_t               side_next[SQRT_STAGES];
    logic [SQRT_X_W-1:0] x_next   [SQRT_STAGES];
    logic [REM_W-1:0]    rem_next [SQRT_STAGES];
    logic [ROOT_W-1:0]   root_next[SQRT_STAGES];

    logic [SQRT_X_W-1:0] sx;
    logic [REM_W-1:0]    srem;
    logic [ROOT_W-1:0]   sroot;
    logic [REM_W+1:0]    rem_sh;
    logic [REM_W+1:0]    trial;
    logic                take;

    always_comb
    begin
        sx     = '0;
        srem   = '0;
        sroot  = '0;
        rem_sh = '0;
        trial  = '0;
        take   = 1'b0;
        for (int k = 0; k < SQRT_STAGES; k++)
        begin
            if (k == 0)
            begin
                sx           = SQRT_X_W'(radicand);
                srem         = '0;
                sroot        = '0;
                side_next[k] = side_in;
            end
            else
            begin
                sx           = x_reg[k - 1];
                srem         = rem_reg[k - 1];
                sroot        = root_reg[k - 1];
                side_next[k] = side_reg[k - 1];
            end
            rem_sh       = {srem, sx[SQRT_X_W-1:SQRT_X_W-2]};
            trial        = {2'b00, sroot, 2'b01};
            take         = rem_sh >= trial;
            rem_next[k]  = take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
            root_next[k] = {sroot[ROOT_W-2:0], take};
            x_next[k]    = sx << 2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SQRT_STAGES; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= valid_in;
            for (int k = 1; k < SQRT_STAGES; k++)
            begin
                vld_reg[k] <= vld_reg[k - 1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg <= side_next;
            x_reg    <= x_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign valid = vld_reg[SQRT_STAGES-1];
    assign side  = side_reg[SQRT_STAGES-1];
    assign root  = root_reg[SQRT_STAGES-1];

endmodule
`default_nettype wire

@@ hdl/adu_back.sv @@
// Back stages: signed step, step average, learning rate scaling, new weight.
`default_nettype none
module adu_back
    import adu_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  logic                    valid_in,
    input  side_t                   side_in,
    input  logic [ROOT_W-1:0]       root,
    input  cfg_t                    cfg,
    output logic                    valid,
    output side_t                   side,
    output logic [AVG_W-1:0]        edx_new,
    output logic signed [VAL_W-1:0] new_weight,
    output logic signed [VAL_W-1:0] applied_step
);

    logic                    vld_reg  [BACK_STAGES];
    side_t                   side_reg [BACK_STAGES];
    side_t                   side_next[BACK_STAGES];
    logic signed [VAL_W-1:0] dx_reg   [BACK_STAGES];
    logic signed [VAL_W-1:0] dx_next  [BACK_STAGES];

    logic [VAL_W-1:0]        udx_reg, udx_next;
    logic [63:0]             sq_reg, sq_next;
    logic signed [63:0]      prod_reg, prod_next;
    logic [AVG_W-1:0]        s2_reg, s2_next;
    logic [63:0]             pe_old_reg [2];
    logic [63:0]             pe_old_next[2];
    logic signed [39:0]      scaled_reg, scaled_next;
    logic [63:0]             pe_new_reg, pe_new_next;
    logic signed [VAL_W-1:0] nw_reg [2];
    logic signed [VAL_W-1:0] nw_next[2];
    logic [AVG_W-1:0]        edx_reg, edx_next;

    logic [ROOT_W-1:0]  m;
    logic               msat;
    logic [16:0]        one_minus_rho;
    logic signed [63:0] rounded;
    logic signed [40:0] nw_wide;
    logic [AVG_W:0]     edx_fin;

    always_comb
    begin
        one_minus_rho = 17'h10000 - {1'b0, cfg.decay_rate};
        for (int k = 0; k < BACK_STAGES; k++)
        begin
            side_next[k] = (k == 0) ? side_in : side_reg[(k == 0) ? 0 : k - 1];
            dx_next[k]   = dx_reg[(k == 0) ? 0 : k - 1];
        end

        // stage 0: sign and clip the root
        m    = root;
        msat = 1'b0;
        if (side_in.gzero)
        begin
            m = '0;
        end
        else if (side_in.gneg)
        begin
            if (m > 32'h7FFF_FFFF)
            begin
                m    = 32'h7FFF_FFFF;
                msat = 1'b1;
            end
        end
        else
        begin
            if (m > 32'h8000_0000)
            begin
                m    = 32'h8000_0000;
                msat = 1'b1;
            end
        end
        udx_next         = m;
        dx_next[0]       = side_in.gneg ? $signed(m) : $signed(VAL_W'(0) - m);
        side_next[0].sat = side_in.sat | msat;

        // stage 1
        sq_next   = 64'(udx_reg) * 64'(udx_reg);
        prod_next = $signed(64'(cfg.step_scale)) * $signed(64'(dx_reg[0]));

        // stage 2: rounding is a floor of (p + 2^23) / 2^24 either sign
        s2_next        = sq_round(sq_reg);
        pe_old_next[0] = 64'(cfg.decay_rate) * 64'(side_reg[1].edx_old);
        rounded        = (prod_reg + 64'sd8388608) >>> 24;
        scaled_next    = rounded[39:0];

        // stage 3
        pe_new_next    = 64'(one_minus_rho) * 64'(s2_reg);
        pe_old_next[1] = pe_old_reg[0];
        nw_wide = $signed({{9{side_reg[2].w[VAL_W-1]}}, side_reg[2].w})
                + $signed({scaled_reg[39], scaled_reg});
        if (nw_wide > 41'sd2147483647)
        begin
            nw_next[0] = 32'sh7FFF_FFFF;
            side_next[3].sat = 1'b1;
        end
        else if (nw_wide < -41'sd2147483648)
        begin
            nw_next[0] = 32'sh8000_0000;
            side_next[3].sat = 1'b1;
        end
        else
        begin
            nw_next[0] = nw_wide[VAL_W-1:0];
        end

        // stage 4: new step average
        edx_fin          = avg_finish(pe_old_reg[1], pe_new_reg);
        edx_next         = edx_fin[AVG_W-1:0];
        side_next[4].sat = side_reg[3].sat | edx_fin[AVG_W];
        nw_next[1]       = nw_reg[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < BACK_STAGES; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= valid_in;
            for (int k = 1; k < BACK_STAGES; k++)
            begin
                vld_reg[k] <= vld_reg[k - 1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg   <= side_next;
            dx_reg     <= dx_next;
            udx_reg    <= udx_next;
            sq_reg     <= sq_next;
            prod_reg   <= prod_next;
            s2_reg     <= s2_next;
            pe_old_reg <= pe_old_next;
            scaled_reg <= scaled_next;
            pe_new_reg <= pe_new_next;
            nw_reg     <= nw_next;
            edx_reg    <= edx_next;
        end
    end

    assign valid        = vld_reg[BACK_STAGES-1];
    assign side         = side_reg[BACK_STAGES-1];
    assign edx_new      = edx_reg;
    assign new_weight   = nw_reg[1];
    assign applied_step = dx_reg[BACK_STAGES-1];

endmodule
`default_nettype wire

@@ hdl/adadelta_param_update_unit.sv @@
// Top level of the AdaDelta parameter update unit.
//
//  channel  | dir | payload                                       | handshake
//  ---------+-----+-----------------------------------------------+-------------
//  items    | in  | element_index, weight_value, gradient_value   | valid/ready
//  results  | out | new_weight, applied_step, saturated           | valid/ready
//  cfg      | in  | cfg_index, cfg_data                           | cfg_we only
//
// One word per cycle unless stalled, held by an index hazard or clearing; a result
// passes the front, divider, square-root and back stages, then the output register.
// A word whose index is still in flight waits until that element has been written
// back. After reset the two average stores are cleared, one entry a cycle, before
// the first word is taken. A stalled result freezes the whole pipeline.
`default_nettype none
module adadelta_param_update_unit
    import adu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    adu_item_if.sink              items,
    adu_result_if.source          results
);

    cfg_t cfg_reg, cfg_next;

    logic             clr_busy_reg, clr_busy_next;
    logic [IDX_W-1:0] clr_addr_reg, clr_addr_next;

    logic             sh_vld_reg  [PIPE_DEPTH];
    logic [IDX_W-1:0] sh_idx_reg  [PIPE_DEPTH];

    logic                    out_valid_reg, out_valid_next;
    logic signed [VAL_W-1:0] nw_reg, nw_next;
    logic signed [VAL_W-1:0] dx_reg, dx_next;
    logic                    sat_reg, sat_next;

    logic adv;
    logic hazard;
    logic accept;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [AVG_W-1:0] eg_wdata, edx_wdata, eg_rdata, edx_rdata;

    logic              f_valid, d_valid, s_valid, b_valid;
    side_t             f_side, d_side, s_side, b_side;
    logic [PROD_W-1:0] f_prod;
    logic [NUM_W-1:0]  f_den;
    logic [QUO_W-1:0]  d_quo;
    logic [ROOT_W-1:0] s_root;
    logic [AVG_W-1:0]  b_edx;
    logic signed [VAL_W-1:0] b_nw, b_dx;

    assign adv = !out_valid_reg || results.ready;

    always_comb
    begin
        hazard = 1'b0;
        for (int k = 0; k < PIPE_DEPTH; k++)
        begin
            hazard = hazard | (sh_vld_reg[k] && (sh_idx_reg[k] == items.element_index));
        end
    end

    assign items.ready = adv && !clr_busy_reg && !hazard;
    assign accept      = items.valid && items.ready;

    // configuration
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_DECAY_RATE:     cfg_next.decay_rate     = cfg_data[RHO_W-1:0];
                REG_STABILITY_TERM: cfg_next.stability_term = cfg_data[EPS_W-1:0];
                REG_STEP_SCALE:     cfg_next.step_scale     = cfg_data[SCALE_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    // clearing pass after reset
    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + IDX_W'(1);
            if (clr_addr_reg == IDX_W'(ELEMENT_COUNT - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        if (clr_busy_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            eg_wdata  = '0;
            edx_wdata = '0;
        end
        else
        begin
            mem_we    = adv && b_valid && b_side.inrange;
            mem_waddr = b_side.idx;
            eg_wdata  = b_side.eg_new;
            edx_wdata = b_edx;
        end
    end

    // output word register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        nw_next        = nw_reg;
        dx_next        = dx_reg;
        sat_next       = sat_reg;
        if (adv)
        begin
            out_valid_next = b_valid;
            if (b_valid)
            begin
                nw_next  = b_nw;
                dx_next  = b_dx;
                sat_next = b_side.sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.decay_rate     <= DECAY_RATE_RESET;
            cfg_reg.stability_term <= STABILITY_TERM_RESET;
            cfg_reg.step_scale     <= STEP_SCALE_RESET;
            clr_busy_reg           <= 1'b1;
            clr_addr_reg           <= '0;
            out_valid_reg          <= 1'b0;
            for (int k = 0; k < PIPE_DEPTH; k++)
            begin
                sh_vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            cfg_reg       <= cfg_next;
            clr_busy_reg  <= clr_busy_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
            if (adv)
            begin
                sh_vld_reg[0] <= accept;
                for (int k = 1; k < PIPE_DEPTH; k++)
                begin
                    sh_vld_reg[k] <= sh_vld_reg[k - 1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        nw_reg  <= nw_next;
        dx_reg  <= dx_next;
        sat_reg <= sat_next;
        if (adv)
        begin
            sh_idx_reg[0] <= items.element_index;
            for (int k = 1; k < PIPE_DEPTH; k++)
            begin
                sh_idx_reg[k] <= sh_idx_reg[k - 1];
            end
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.new_weight   = nw_reg;
    assign results.applied_step = dx_reg;
    assign results.saturated    = sat_reg;

    adu_avg_mem u_eg_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (eg_wdata),
        .re    (adv),
        .raddr (items.element_index),
        .rdata (eg_rdata)
    );

    adu_avg_mem u_edx_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (edx_wdata),
        .re    (adv),
        .raddr (items.element_index),
        .rdata (edx_rdata)
    );

    adu_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .adv            (adv),
        .accept         (accept),
        .element_index  (items.element_index),
        .weight_value   (items.weight_value),
        .gradient_value (items.gradient_value),
        .eg_rdata       (eg_rdata),
        .edx_rdata      (edx_rdata),
        .cfg            (cfg_reg),
        .valid          (f_valid),
        .side           (f_side),
        .prod           (f_prod),
        .den            (f_den)
    );

    adu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .valid_in (f_valid),
        .side_in  (f_side),
        .prod     (f_prod),
        .den      (f_den),
        .valid    (d_valid),
        .side     (d_side),
        .quo      (d_quo)
    );

    adu_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .valid_in (d_valid),
        .side_in  (d_side),
        .radicand (d_quo),
        .valid    (s_valid),
        .side     (s_side),
        .root     (s_root)
    );

    adu_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .valid_in     (s_valid),
        .side_in      (s_side),
        .root         (s_root),
        .cfg          (cfg_reg),
        .valid        (b_valid),
        .side         (b_side),
        .edx_new      (b_edx),
        .new_weight   (b_nw),
        .applied_step (b_dx)
    );

endmodule
`default_nettype wire

@@ hdl/adu_checker.sv @@
// Port-level checks for the update unit, bound to the top level.
`default_nettype none
module adu_checker
    import adu_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic signed [VAL_W-1:0] new_weight,
    input logic signed [VAL_W-1:0] applied_step,
    input logic                    saturated
);

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(new_weight)
                                    && $stable(applied_step) && $stable(saturated))
        else $error("result word changed while stalled");

    // the stores are being cleared right after reset
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |=> !in_ready)
        else $error("word taken during clearing pass");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("result present straight after reset");

    // a zero step leaves the weight as it was, so nothing can clip
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (applied_step == '0) |-> !saturated)
        else $error("saturation flagged on a zero step");

endmodule

bind adadelta_param_update_unit adu_checker u_adu_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (items.ready),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .new_weight   (results.new_weight),
    .applied_step (results.applied_step),
    .saturated    (results.saturated)
);
`default_nettype wire

@@ sim/adu_update_checker.sv @@
// Watches the item, result and register ports, predicts each result and compares.
`timescale 1ns / 100ps
module adu_update_checker
    import adu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    adu_item_if                   items,
    adu_result_if                 results,
    output int                    errors,
    output int                    pending
);

    typedef struct {
        logic signed [VAL_W-1:0] new_weight;
        logic signed [VAL_W-1:0] applied_step;
        logic                    saturated;
    } update_t;

    logic [AVG_W-1:0]   grad_avg [ELEMENT_COUNT];
    logic [AVG_W-1:0]   step_avg [ELEMENT_COUNT];
    logic [RHO_W-1:0]   rho;
    logic [EPS_W-1:0]   eps;
    logic [SCALE_W-1:0] lr;
    update_t            expected_updates [$];

    assign pending = expected_updates.size();

    function automatic logic [AVG_W-1:0] square_q(input logic [63:0] m);
        return AVG_W'((m * m + 64'd32768) >> 16);
    endfunction

    function automatic logic [AVG_W-1:0] decay_mix(input logic [AVG_W-1:0] old_v,
                                                   input logic [AVG_W-1:0] sq,
                                                   inout logic sat);
        logic [64:0] s;
        logic [64:0] v;
        s = 65'(rho) * 65'(old_v) + (65'(65536) - 65'(rho)) * 65'(sq) + 65'(32768);
        v = s >> 16;
        if (v > 65'({AVG_W{1'b1}}))
        begin
            sat = 1'b1;
            return {AVG_W{1'b1}};
        end
        return v[AVG_W-1:0];
    endfunction

    function automatic logic [63:0] floor_root(input logic [63:0] x);
        logic [63:0] r;
        logic [64:0] t;
        r = 0;
        for (int b = 31; b >= 0; b--)
        begin
            t = 65'(r | (64'd1 << b));
            if (t * t <= 65'(x))
                r = t[63:0];
        end
        return r;
    endfunction

    function automatic update_t predict_update(input logic [IDX_W-1:0] idx,
                                               input logic signed [VAL_W-1:0] w,
                                               input logic signed [VAL_W-1:0] g);
        update_t     u;
        logic        sat;
        logic [63:0] ug;
        logic [63:0] m;
        logic [AVG_W-1:0] eg;
        logic [AVG_W-1:0] edx;
        logic [127:0] numer;
        logic [127:0] quo;
        logic [63:0]  den;
        longint       dx;
        longint       prod;
        longint       nw;
        sat = 1'b0;
        ug  = (g < 0) ? 64'(-longint'(g)) : 64'(longint'(g));
        eg  = decay_mix(grad_avg[idx], square_q(ug), sat);
        edx = step_avg[idx];
        den = 64'(eg) + 64'(eps);
        if (den == 0)
            den = 1;
        numer = 128'(ug * ug) * 128'(64'(edx) + 64'(eps));
        quo   = numer / 128'(den);
        m = floor_root((quo[127:64] != 0) ? {64{1'b1}} : quo[63:0]);
        if (g < 0)
        begin
            if (m > 64'd2147483647)
            begin
                m   = 64'd2147483647;
                sat = 1'b1;
            end
            dx = longint'(m);
        end
        else if (g > 0)
        begin
            if (m > 64'd2147483648)
            begin
                m   = 64'd2147483648;
                sat = 1'b1;
            end
            dx = -longint'(m);
        end
        else
            dx = 0;
        edx = decay_mix(edx, square_q(64'((dx < 0) ? -dx : dx)), sat);
        grad_avg[idx] = eg;
        step_avg[idx] = edx;
        prod = longint'(lr) * dx + 64'sd8388608;
        nw   = longint'(w) + (prod >>> 24);
        if (nw > 64'sd2147483647)
        begin
            nw  = 64'sd2147483647;
            sat = 1'b1;
        end
        else if (nw < -64'sd2147483648)
        begin
            nw  = -64'sd2147483648;
            sat = 1'b1;
        end
        u.new_weight   = nw[31:0];
        u.applied_step = dx[31:0];
        u.saturated    = sat;
        return u;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        update_t e;
        if (!rst_n)
        begin
            for (int i = 0; i < ELEMENT_COUNT; i++)
            begin
                grad_avg[i] = '0;
                step_avg[i] = '0;
            end
            rho    = DECAY_RATE_RESET;
            eps    = STABILITY_TERM_RESET;
            lr     = STEP_SCALE_RESET;
            errors = 0;
            expected_updates.delete();
        end
        else
        begin
            if (results.valid && results.ready)
            begin
                if (expected_updates.size() == 0)
                begin
                    $error("result word with nothing expected");
                    errors++;
                end
                else
                begin
                    e = expected_updates.pop_front();
                    if (results.new_weight !== e.new_weight)
                    begin
                        $error("new_weight: expected %0d, got %0d",
                               e.new_weight, results.new_weight);
                        errors++;
                    end
                    if (results.applied_step !== e.applied_step)
                    begin
                        $error("applied_step: expected %0d, got %0d",
                               e.applied_step, results.applied_step);
                        errors++;
                    end
                    if (results.saturated !== e.saturated)
                    begin
                        $error("saturated: expected %0b, got %0b",
                               e.saturated, results.saturated);
                        errors++;
                    end
                end
            end
            if (items.valid && items.ready)
                expected_updates.push_back(predict_update(items.element_index,
                                                          items.weight_value,
                                                          items.gradient_value));
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_DECAY_RATE:     rho = cfg_data[RHO_W-1:0];
                    REG_STABILITY_TERM: eps = cfg_data[EPS_W-1:0];
                    REG_STEP_SCALE:     lr  = cfg_data[SCALE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

@@ sim/adadelta_param_update_unit_test.sv @@
// Stimulus, register settings and verdict for the AdaDelta update unit.
`timescale 1ns / 100ps
module adadelta_param_update_unit_test;
    import adu_pkg::*;

    localparam longint CYCLE_LIMIT = 1500000;
    localparam int     PHASE_ITEMS = 300;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    errors;
    int                    pending;
    int                    idle_mode = 0;
    longint                cycles = 0;

    adu_item_if   items ();
    adu_result_if results ();

    adadelta_param_update_unit DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .items(items), .results(results)
    );

    adu_update_checker u_checker (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .items(items), .results(results),
        .errors(errors), .pending(pending)
    );

    always #10 clk = ~clk;

    initial
    begin
        items.valid          = 1'b0;
        items.element_index  = '0;
        items.weight_value   = '0;
        items.gradient_value = '0;
        results.ready        = 1'b0;
    end

    // receiver stalls: mode 2 stalls 62 in 100, mode 3 stalls 30 in 100
    always @(negedge clk)
    begin
        case (idle_mode)
            2:       results.ready <= ($urandom_range(99) >= 62);
            3:       results.ready <= ($urandom_range(99) >= 30);
            default: results.ready <= 1'b1;
        endcase
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("adadelta_param_update_unit: mismatch");
            $finish;
        end
    end

    task automatic send_word(input logic [IDX_W-1:0] idx,
                             input logic signed [VAL_W-1:0] w,
                             input logic signed [VAL_W-1:0] g);
        int gap;
        gap = 0;
        if (idle_mode == 1 && $urandom_range(99) < 62)
            gap = $urandom_range(1, 4);
        else if (idle_mode == 3 && $urandom_range(99) < 30)
            gap = $urandom_range(1, 3);
        if (gap > 0)
        begin
            items.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        items.valid          = 1'b1;
        items.element_index  = idx;
        items.weight_value   = w;
        items.gradient_value = g;
        do @(posedge clk); while (!items.ready);
        @(negedge clk);
    endtask

    task automatic wait_drained;
        items.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] v);
        cfg_we    = 1'b1;
        cfg_index = r;
        cfg_data  = v;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic random_words(input int n);
        logic [IDX_W-1:0]        idx;
        logic signed [VAL_W-1:0] w;
        logic signed [VAL_W-1:0] g;
        for (int i = 0; i < n; i++)
        begin
            // hot set of indices drives back-to-back repeats; top indices kept fresh
            idx = ($urandom_range(1)) ? IDX_W'($urandom_range(15))
                                      : IDX_W'($urandom_range(4031));
            case ($urandom_range(3))
                0:       g = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
                1:       g = (1 << $urandom_range(30)) * ($urandom_range(1) ? 1 : -1);
                2:       g = $urandom;
                default: g = ($urandom_range(9) == 0) ? 0 : $urandom_range(0, 4096) - 2048;
            endcase
            case ($urandom_range(7))
                0:       w = 32'sh7FFF_FFFF - $urandom_range(0, 255);
                1:       w = 32'sh8000_0000 + $urandom_range(0, 255);
                default: w = $urandom;
            endcase
            send_word(idx, w, g);
        end
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // edge cases under reset settings
        send_word(12'd0, 32'sd0, 32'sd0);
        send_word(12'd4095, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_word(12'd4095, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_word(12'd4095, 32'sh7FFF_FFFF, -32'sd1);
        send_word(12'd1, 32'sh8000_0000, 32'sd1);
        send_word(12'd1, 32'sd0, 32'sh0100_0000);
        send_word(12'd1, 32'sd0, -32'sh0100_0000);
        send_word(12'd2, 32'sh7FFF_FF00, -32'sh7FFF_FFFF);
        send_word(12'd3, 32'sh8000_0100, 32'sh7FFF_FFFF);
        send_word(12'd2730, 32'shAAAA_AAAA, 32'sh5555_5555);
        send_word(12'd1365, 32'sh5555_5555, 32'shAAAA_AAAA);
        send_word(12'd1365, 32'sh1234_5678, 32'sd0);
        random_words(PHASE_ITEMS);
        wait_drained();

        idle_mode = 1;
        write_reg(REG_DECAY_RATE, 32'd0);
        write_reg(REG_STABILITY_TERM, 32'd1);
        write_reg(REG_STEP_SCALE, 32'h7FFF_FFFF);
        send_word(12'd5, 32'sd0, 32'sh7FFF_FFFF);
        send_word(12'd6, 32'sd0, 32'sh8000_0000);
        random_words(PHASE_ITEMS);
        wait_drained();

        idle_mode = 2;
        write_reg(REG_DECAY_RATE, 32'd65535);
        write_reg(REG_STABILITY_TERM, 32'hFFFF_FFFF);
        write_reg(REG_STEP_SCALE, 32'd1);
        random_words(PHASE_ITEMS);
        wait_drained();

        // zero epsilon: a fresh element with zero gradient has a zero denominator, forced to one
        idle_mode = 3;
        write_reg(REG_DECAY_RATE, 32'd32768);
        write_reg(REG_STABILITY_TERM, 32'd0);
        write_reg(REG_STEP_SCALE, 32'd16777216);
        send_word(12'd4050, 32'sd77, 32'sd0);
        send_word(12'd4051, 32'sd0, 32'sd1);
        random_words(PHASE_ITEMS);
        wait_drained();

        idle_mode = 0;
        write_reg(REG_DECAY_RATE, $urandom);
        write_reg(REG_STABILITY_TERM, $urandom);
        write_reg(REG_STEP_SCALE, $urandom);
        random_words(PHASE_ITEMS);
        wait_drained();

        idle_mode = 2;
        write_reg(REG_DECAY_RATE, 32'd62259);
        write_reg(REG_STABILITY_TERM, 32'd4295);
        write_reg(REG_STEP_SCALE, 32'h4000_0000);
        random_words(PHASE_ITEMS);
        wait_drained();

        repeat (150) @(negedge clk);
        if (errors == 0)
            $display("adadelta_param_update_unit: match");
        else
            $display("adadelta_param_update_unit: mismatch");
        $finish;
    end

endmodule
